@@ rtl/tcs_pkg.sv @@
`default_nettype none

package tcs_pkg;

    // Vertex coordinate width and the widths that follow from it
    localparam int COORD_W = 20;
    localparam int EDGE_W  = COORD_W + 1;        // edge vector from the first vertex
    localparam int PROD_W  = 2 * EDGE_W;         // edge by edge product
    localparam int COF_W   = PROD_W + 1;         // 2x2 cofactor
    localparam int RSQ_W   = PROD_W;             // squared edge length, unsigned
    localparam int RLO_W   = RSQ_W / 2;
    localparam int RHI_W   = RSQ_W - RLO_W;
    localparam int DT_W    = EDGE_W + COF_W;     // one term of the determinant
    localparam int NP_W    = RHI_W + 1 + COF_W;  // one half term of a numerator
    localparam int DET_W   = DT_W + 2;
    localparam int N_W     = NP_W + RLO_W + 2;
    localparam int NUM_W   = N_W + 1;            // numerator plus 2*D*a
    localparam int NMAG_W  = N_W - 1;
    localparam int LIMB_N  = NMAG_W / 3;
    localparam int DMAG_W  = DET_W;
    localparam int LIMB_D  = DMAG_W / 3;
    localparam int DEN_W   = DMAG_W + 1;         // |2D|
    localparam int DLO_W   = DET_W / 2;
    localparam int DHI_W   = DET_W - DLO_W;
    localparam int PLO_W   = DLO_W + 1 + COORD_W;
    localparam int PHI_W   = DHI_W + COORD_W;

    // Result widths and the iteration datapath
    localparam int OUT_W   = 32;
    localparam int QUO_W   = OUT_W;
    localparam int DREM_W  = DEN_W + QUO_W;
    localparam int ROWN_W  = 4 * LIMB_N + 2;
    localparam int NSQ_W   = 2 * NMAG_W + 2;
    localparam int S_W     = NSQ_W + 2;
    localparam int ROWD_W  = 4 * LIMB_D + 2;
    localparam int T_W     = 2 * DMAG_W + 4;
    localparam int Y_W     = T_W + QUO_W;
    localparam int SREM_W  = T_W + 2 * QUO_W + 1;

    localparam logic [OUT_W-1:0] SAT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] SAT_UMAX = {OUT_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] dz;
    } t_tet;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic signed [OUT_W-1:0] center_z;
        logic        [OUT_W-1:0] sphere_radius;
        logic                    degenerate;
        logic                    overflowed;
    } t_sph;

    // Determinant and Cramer numerators relative to the first vertex
    typedef struct packed {
        logic signed [DET_W-1:0]   det;
        logic signed [N_W-1:0]     nx;
        logic signed [N_W-1:0]     ny;
        logic signed [N_W-1:0]     nz;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
    } t_geom;

endpackage

`default_nettype wire

@@ rtl/tcs_if.sv @@
`default_nettype none

interface tcs_tet_if;
    logic          valid;
    logic          ready;
    tcs_pkg::t_tet data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcs_sph_if;
    logic          valid;
    logic          ready;
    tcs_pkg::t_sph data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tcs_geom.sv @@
`default_nettype none

module tcs_geom (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire tcs_pkg::t_tet  i_tet,
    output logic                o_valid,
    output tcs_pkg::t_geom      o_geom
);

    localparam int NXT [3] = '{1, 2, 0};
    localparam int NNX [3] = '{2, 0, 1};

    logic signed [tcs_pkg::COORD_W-1:0] w_p [4][3];
    logic signed [tcs_pkg::N_W-1:0]     w_n [3];
    logic signed [tcs_pkg::DET_W-1:0]   w_det;

    logic [4:0] r_vld;

    logic signed [tcs_pkg::EDGE_W-1:0]  r_e1  [3][3];
    logic signed [tcs_pkg::COORD_W-1:0] r_a1  [3];
    logic signed [tcs_pkg::PROD_W-1:0]  r_cp  [3][3][2];
    logic signed [tcs_pkg::PROD_W-1:0]  r_sq  [3][3];
    logic signed [tcs_pkg::EDGE_W-1:0]  r_e2  [3];
    logic signed [tcs_pkg::COORD_W-1:0] r_a2  [3];
    logic signed [tcs_pkg::COF_W-1:0]   r_cof [3][3];
    logic        [tcs_pkg::RSQ_W-1:0]   r_rsq [3];
    logic signed [tcs_pkg::EDGE_W-1:0]  r_e3  [3];
    logic signed [tcs_pkg::COORD_W-1:0] r_a3  [3];
    logic signed [tcs_pkg::DT_W-1:0]    r_dt  [3];
    logic signed [tcs_pkg::NP_W-1:0]    r_nl  [3][3];
    logic signed [tcs_pkg::NP_W-1:0]    r_nh  [3][3];
    logic signed [tcs_pkg::COORD_W-1:0] r_a4  [3];
    tcs_pkg::t_geom                     r_geom;

    // unpack the vertices
    always_comb begin
        w_p[0][0] = i_tet.ax; w_p[0][1] = i_tet.ay; w_p[0][2] = i_tet.az;
        w_p[1][0] = i_tet.bx; w_p[1][1] = i_tet.by; w_p[1][2] = i_tet.bz;
        w_p[2][0] = i_tet.cx; w_p[2][1] = i_tet.cy; w_p[2][2] = i_tet.cz;
        w_p[3][0] = i_tet.dx; w_p[3][1] = i_tet.dy; w_p[3][2] = i_tet.dz;
    end

    // advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // edges from the first vertex, then edge products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a1[i] <= w_p[0][i];
                for (int j = 0; j < 3; j++) begin
                    r_e1[i][j] <= tcs_pkg::EDGE_W'(w_p[i+1][j]) - tcs_pkg::EDGE_W'(w_p[0][j]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                r_a2[i] <= r_a1[i];
                r_e2[i] <= r_e1[0][i];
                for (int j = 0; j < 3; j++) begin
                    r_sq[i][j]    <= r_e1[i][j] * r_e1[i][j];
                    r_cp[i][j][0] <= r_e1[NXT[i]][NXT[j]] * r_e1[NNX[i]][NNX[j]];
                    r_cp[i][j][1] <= r_e1[NXT[i]][NNX[j]] * r_e1[NNX[i]][NXT[j]];
                end
            end
        end
    end

    // cofactors and squared edge lengths
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a3[i]  <= r_a2[i];
                r_e3[i]  <= r_e2[i];
                r_rsq[i] <= $unsigned(r_sq[i][0]) + $unsigned(r_sq[i][1])
                          + $unsigned(r_sq[i][2]);
                for (int j = 0; j < 3; j++) begin
                    r_cof[i][j] <= tcs_pkg::COF_W'(r_cp[i][j][0])
                                 - tcs_pkg::COF_W'(r_cp[i][j][1]);
                end
            end
        end
    end

    // determinant terms and numerator halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_a4[j] <= r_a3[j];
                r_dt[j] <= r_e3[j] * r_cof[0][j];
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_nl[i][j] <= $signed({1'b0, r_rsq[i][tcs_pkg::RLO_W-1:0]}) * r_cof[i][j];
                    r_nh[i][j] <= $signed({1'b0, r_rsq[i][tcs_pkg::RSQ_W-1:tcs_pkg::RLO_W]})
                                * r_cof[i][j];
                end
            end
        end
    end

    // sum the terms
    always_comb begin
        w_det = tcs_pkg::DET_W'(r_dt[0]) + tcs_pkg::DET_W'(r_dt[1])
              + tcs_pkg::DET_W'(r_dt[2]);
        for (int j = 0; j < 3; j++) begin
            w_n[j] = '0;
            for (int i = 0; i < 3; i++) begin
                w_n[j] = w_n[j] + (tcs_pkg::N_W'(r_nh[i][j]) <<< tcs_pkg::RLO_W)
                       + tcs_pkg::N_W'(r_nl[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom.det <= w_det;
            r_geom.nx  <= w_n[0];
            r_geom.ny  <= w_n[1];
            r_geom.nz  <= w_n[2];
            r_geom.ax  <= r_a4[0];
            r_geom.ay  <= r_a4[1];
            r_geom.az  <= r_a4[2];
        end
    end

    assign o_valid = r_vld[4];
    assign o_geom  = r_geom;

endmodule

`default_nettype wire

@@ rtl/tetrahedron_circumsphere_unit.sv @@
`default_nettype none

// Tetrahedron circumsphere unit.
// i_tet carries one tetrahedron per word: four vertices a, b, c, d as signed
// fixed-point coordinates. o_sph returns one word per tetrahedron: center,
// radius (rounded down), a degenerate flag (zero determinant, all outputs zero)
// and an overflow flag (a center coordinate or the radius saturated).
// Both channels move a word when valid and ready are high at a clock edge.
// Throughput is one word per cycle while the output is not stalled. A word
// passes the stages that build the determinant and Cramer numerators, the
// stages that form |2D|, the numerators and the squared norms, the iteration
// load register, 32 one-bit stages that each retire one quotient bit of the
// three center divisions and one root bit of the radius, and the saturating
// output register. The 32 one-bit iteration stages set most of the latency.
// The whole pipeline advances together: when the output word is held by a low
// o_sph.ready, i_tet.ready drops and every stage holds, so nothing is lost or
// repeated. Synchronous active-low reset clears all valid bits; the data
// registers are not reset.
module tetrahedron_circumsphere_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcs_tet_if.sink   i_tet,
    tcs_sph_if.source o_sph
);

    typedef struct packed {
        logic [2:0][tcs_pkg::QUO_W-1:0]  quo;
        logic [2:0][tcs_pkg::DREM_W-1:0] drem;
        logic [tcs_pkg::DEN_W-1:0]       den;
        logic [2:0]                      negq;
        logic [2:0]                      dovf;
        logic [tcs_pkg::SREM_W-1:0]      srem;
        logic [tcs_pkg::T_W-1:0]         tval;
        logic [tcs_pkg::Y_W-1:0]         yval;
        logic [tcs_pkg::OUT_W-1:0]       root;
        logic                            sovf;
        logic                            deg;
    } t_it;

    // one restoring step: a quotient bit per center and a root bit of S / T
    function automatic t_it f_step(input t_it x, input int b);
        t_it                        y;
        logic [tcs_pkg::DREM_W-1:0] trial;
        logic [tcs_pkg::SREM_W-1:0] cand;
        y     = x;
        trial = tcs_pkg::DREM_W'(x.den) << b;
        for (int j = 0; j < 3; j++) begin
            if (x.drem[j] >= trial) begin
                y.drem[j] = x.drem[j] - trial;
                y.quo[j]  = x.quo[j] | (tcs_pkg::QUO_W'(1) << b);
            end
        end
        cand = (tcs_pkg::SREM_W'(x.yval) << (b + 1)) + (tcs_pkg::SREM_W'(x.tval) << (2 * b));
        if (x.srem >= cand) begin
            y.srem = x.srem - cand;
            y.yval = x.yval + (tcs_pkg::Y_W'(x.tval) << b);
            y.root = x.root | (tcs_pkg::OUT_W'(1) << b);
        end
        return y;
    endfunction

    logic           w_en;
    logic           w_gvld;
    tcs_pkg::t_geom w_geom;

    logic signed [tcs_pkg::N_W-1:0]     w_gn   [3];
    logic signed [tcs_pkg::COORD_W-1:0] w_ga   [3];
    logic signed [tcs_pkg::N_W-1:0]     w_nabs [3];
    logic signed [tcs_pkg::DET_W-1:0]   w_dabs;
    logic        [tcs_pkg::LIMB_N-1:0]  w_nl   [3][3];
    logic        [tcs_pkg::LIMB_D-1:0]  w_dl   [3];
    logic signed [tcs_pkg::NUM_W-1:0]   w_nmneg[3];
    logic        [tcs_pkg::ROWN_W-1:0]  w_rown [3][3];
    logic        [tcs_pkg::ROWD_W-1:0]  w_rowd [3];
    logic        [tcs_pkg::NSQ_W-1:0]   w_nsq  [3];
    logic        [tcs_pkg::T_W-1:0]     w_tsum;
    t_it                                w_fin;
    logic        [tcs_pkg::OUT_W-1:0]   w_cen  [3];
    logic        [tcs_pkg::OUT_W-1:0]   w_rad;
    logic                               w_ovf;

    logic r_vld6, r_vld7, r_vld8, r_vld9, r_vld10, r_ovld;
    logic [tcs_pkg::QUO_W:0] r_itv;

    logic signed [tcs_pkg::N_W-1:0]     r6_n    [3];
    logic signed [tcs_pkg::PLO_W-1:0]   r6_plo  [3];
    logic signed [tcs_pkg::PHI_W-1:0]   r6_phi  [3];
    logic        [tcs_pkg::NMAG_W-1:0]  r6_nmag [3];
    logic        [tcs_pkg::DMAG_W-1:0]  r6_dmag;
    logic                               r6_dneg;
    logic                               r6_deg;

    logic signed [tcs_pkg::NUM_W-1:0]   r7_num  [3];
    logic        [2*tcs_pkg::LIMB_N-1:0] r7_pp  [3][3][3];
    logic        [2*tcs_pkg::LIMB_D-1:0] r7_pd  [3][3];
    logic        [tcs_pkg::DMAG_W-1:0]  r7_dmag;
    logic                               r7_dneg;
    logic                               r7_deg;

    logic        [tcs_pkg::NUM_W-1:0]   r8_nummag [3];
    logic        [2:0]                  r8_numneg;
    logic        [tcs_pkg::ROWN_W-1:0]  r8_rown   [3][3];
    logic        [tcs_pkg::ROWD_W-1:0]  r8_rowd   [3];
    logic        [tcs_pkg::DEN_W-1:0]   r8_den;
    logic                               r8_dneg;
    logic                               r8_deg;

    logic        [tcs_pkg::NSQ_W-1:0]   r9_nsq    [3];
    logic        [tcs_pkg::T_W-1:0]     r9_tval;
    logic        [tcs_pkg::NUM_W-1:0]   r9_nummag [3];
    logic        [2:0]                  r9_negq;
    logic        [2:0]                  r9_dovf;
    logic        [tcs_pkg::DEN_W-1:0]   r9_den;
    logic                               r9_deg;

    logic        [tcs_pkg::S_W-1:0]     r10_s;
    logic        [tcs_pkg::T_W-1:0]     r10_tval;
    logic        [tcs_pkg::NUM_W-1:0]   r10_nummag [3];
    logic        [2:0]                  r10_negq;
    logic        [2:0]                  r10_dovf;
    logic        [tcs_pkg::DEN_W-1:0]   r10_den;
    logic                               r10_deg;

    t_it           r_it [0:tcs_pkg::QUO_W];
    tcs_pkg::t_sph r_out;

    // stall everything while the output word waits
    assign w_en        = !r_ovld || o_sph.ready;
    assign i_tet.ready = w_en;
    assign o_sph.valid = r_ovld;
    assign o_sph.data  = r_out;

    tcs_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_tet.valid),
        .i_tet   (i_tet.data),
        .o_valid (w_gvld),
        .o_geom  (w_geom)
    );

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6  <= 1'b0;
            r_vld7  <= 1'b0;
            r_vld8  <= 1'b0;
            r_vld9  <= 1'b0;
            r_vld10 <= 1'b0;
            r_itv   <= '0;
            r_ovld  <= 1'b0;
        end else if (w_en) begin
            r_vld6  <= w_gvld;
            r_vld7  <= r_vld6;
            r_vld8  <= r_vld7;
            r_vld9  <= r_vld8;
            r_vld10 <= r_vld9;
            r_itv   <= {r_itv[tcs_pkg::QUO_W-1:0], r_vld10};
            r_ovld  <= r_itv[tcs_pkg::QUO_W];
        end
    end

    // magnitudes and the D*a partial products
    always_comb begin
        w_gn[0] = w_geom.nx; w_gn[1] = w_geom.ny; w_gn[2] = w_geom.nz;
        w_ga[0] = w_geom.ax; w_ga[1] = w_geom.ay; w_ga[2] = w_geom.az;
        for (int j = 0; j < 3; j++) begin
            w_nabs[j] = w_gn[j][tcs_pkg::N_W-1] ? -w_gn[j] : w_gn[j];
        end
        w_dabs = w_geom.det[tcs_pkg::DET_W-1] ? -w_geom.det : w_geom.det;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r6_n[j]    <= w_gn[j];
                r6_plo[j]  <= $signed({1'b0, w_geom.det[tcs_pkg::DLO_W-1:0]}) * w_ga[j];
                r6_phi[j]  <= $signed(w_geom.det[tcs_pkg::DET_W-1:tcs_pkg::DLO_W]) * w_ga[j];
                r6_nmag[j] <= w_nabs[j][tcs_pkg::NMAG_W-1:0];
            end
            r6_dmag <= $unsigned(w_dabs);
            r6_dneg <= w_geom.det[tcs_pkg::DET_W-1];
            r6_deg  <= (w_geom.det == '0);
        end
    end

    // full numerators and limb products of the squares
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                w_nl[j][k] = r6_nmag[j][tcs_pkg::LIMB_N*k +: tcs_pkg::LIMB_N];
            end
        end
        for (int k = 0; k < 3; k++) begin
            w_dl[k] = r6_dmag[tcs_pkg::LIMB_D*k +: tcs_pkg::LIMB_D];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r7_num[j] <= tcs_pkg::NUM_W'(r6_n[j])
                           + (tcs_pkg::NUM_W'(r6_phi[j]) <<< (tcs_pkg::DLO_W + 1))
                           + (tcs_pkg::NUM_W'(r6_plo[j]) <<< 1);
                for (int k = 0; k < 3; k++) begin
                    for (int l = 0; l < 3; l++) begin
                        r7_pp[j][k][l] <= w_nl[j][k] * w_nl[j][l];
                    end
                end
            end
            for (int k = 0; k < 3; k++) begin
                for (int l = 0; l < 3; l++) begin
                    r7_pd[k][l] <= w_dl[k] * w_dl[l];
                end
            end
            r7_dmag <= r6_dmag;
            r7_dneg <= r6_dneg;
            r7_deg  <= r6_deg;
        end
    end

    // numerator magnitudes and row sums of the squares
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_nmneg[j] = -r7_num[j];
            for (int k = 0; k < 3; k++) begin
                w_rown[j][k] = '0;
                for (int l = 0; l < 3; l++) begin
                    w_rown[j][k] = w_rown[j][k]
                                 + (tcs_pkg::ROWN_W'(r7_pp[j][k][l]) << (tcs_pkg::LIMB_N * l));
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            w_rowd[k] = '0;
            for (int l = 0; l < 3; l++) begin
                w_rowd[k] = w_rowd[k]
                          + (tcs_pkg::ROWD_W'(r7_pd[k][l]) << (tcs_pkg::LIMB_D * l));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r8_numneg[j] <= r7_num[j][tcs_pkg::NUM_W-1];
                r8_nummag[j] <= r7_num[j][tcs_pkg::NUM_W-1] ? $unsigned(w_nmneg[j])
                                                            : $unsigned(r7_num[j]);
                r8_rown[j]   <= w_rown[j];
            end
            r8_rowd <= w_rowd;
            r8_den  <= {r7_dmag, 1'b0};
            r8_dneg <= r7_dneg;
            r8_deg  <= r7_deg;
        end
    end

    // squares, 4*D^2 and the quotient range check
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_nsq[j] = '0;
            for (int k = 0; k < 3; k++) begin
                w_nsq[j] = w_nsq[j] + (tcs_pkg::NSQ_W'(r8_rown[j][k]) << (tcs_pkg::LIMB_N * k));
            end
        end
        w_tsum = '0;
        for (int k = 0; k < 3; k++) begin
            w_tsum = w_tsum + (tcs_pkg::T_W'(r8_rowd[k]) << (tcs_pkg::LIMB_D * k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r9_nsq[j]    <= w_nsq[j];
                r9_nummag[j] <= r8_nummag[j];
                r9_negq[j]   <= r8_numneg[j] ^ r8_dneg;
                r9_dovf[j]   <= tcs_pkg::DREM_W'(r8_nummag[j])
                             >= (tcs_pkg::DREM_W'(r8_den) << tcs_pkg::QUO_W);
            end
            r9_tval <= w_tsum << 2;
            r9_den  <= r8_den;
            r9_deg  <= r8_deg;
        end
    end

    // sum of squared numerators
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_s      <= tcs_pkg::S_W'(r9_nsq[0]) + tcs_pkg::S_W'(r9_nsq[1])
                        + tcs_pkg::S_W'(r9_nsq[2]);
            r10_tval   <= r9_tval;
            r10_nummag <= r9_nummag;
            r10_negq   <= r9_negq;
            r10_dovf   <= r9_dovf;
            r10_den    <= r9_den;
            r10_deg    <= r9_deg;
        end
    end

    // load the iteration word; flag a radius of 2^32 or more
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_it[0].quo[j]  <= '0;
                r_it[0].drem[j] <= tcs_pkg::DREM_W'(r10_nummag[j]);
            end
            r_it[0].den  <= r10_den;
            r_it[0].negq <= r10_negq;
            r_it[0].dovf <= r10_dovf;
            r_it[0].srem <= tcs_pkg::SREM_W'(r10_s);
            r_it[0].tval <= r10_tval;
            r_it[0].yval <= '0;
            r_it[0].root <= '0;
            r_it[0].sovf <= tcs_pkg::SREM_W'(r10_s)
                         >= (tcs_pkg::SREM_W'(r10_tval) << (2 * tcs_pkg::QUO_W));
            r_it[0].deg  <= r10_deg;
        end
    end

    // one bit per stage, most significant first
    for (genvar k = 0; k < tcs_pkg::QUO_W; k++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_it[k+1] <= f_step(r_it[k], tcs_pkg::QUO_W - 1 - k);
            end
        end
    end

    // sign, saturate and drop degenerate results
    always_comb begin
        w_fin = r_it[tcs_pkg::QUO_W];
        w_ovf = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (w_fin.dovf[j]) begin
                w_cen[j] = w_fin.negq[j] ? tcs_pkg::SAT_MIN : tcs_pkg::SAT_MAX;
                w_ovf    = 1'b1;
            end else if (w_fin.negq[j]) begin
                if (w_fin.quo[j] > tcs_pkg::SAT_MIN) begin
                    w_cen[j] = tcs_pkg::SAT_MIN;
                    w_ovf    = 1'b1;
                end else begin
                    w_cen[j] = -w_fin.quo[j];
                end
            end else if (w_fin.quo[j] > tcs_pkg::SAT_MAX) begin
                w_cen[j] = tcs_pkg::SAT_MAX;
                w_ovf    = 1'b1;
            end else begin
                w_cen[j] = w_fin.quo[j];
            end
        end
        if (w_fin.sovf) begin
            w_rad = tcs_pkg::SAT_UMAX;
            w_ovf = 1'b1;
        end else begin
            w_rad = w_fin.root;
        end
        if (w_fin.deg) begin
            for (int j = 0; j < 3; j++) begin
                w_cen[j] = '0;
            end
            w_rad = '0;
            w_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.center_x      <= $signed(w_cen[0]);
            r_out.center_y      <= $signed(w_cen[1]);
            r_out.center_z      <= $signed(w_cen[2]);
            r_out.sphere_radius <= w_rad;
            r_out.degenerate    <= w_fin.deg;
            r_out.overflowed    <= w_ovf;
        end
    end

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sph.valid && !o_sph.ready) |-> !i_tet.ready)
        else $error("input taken while output word is stalled");

    a_ovf_means_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sph.valid && o_sph.data.overflowed) |->
        ($unsigned(o_sph.data.center_x) == tcs_pkg::SAT_MAX ||
         $unsigned(o_sph.data.center_x) == tcs_pkg::SAT_MIN ||
         $unsigned(o_sph.data.center_y) == tcs_pkg::SAT_MAX ||
         $unsigned(o_sph.data.center_y) == tcs_pkg::SAT_MIN ||
         $unsigned(o_sph.data.center_z) == tcs_pkg::SAT_MAX ||
         $unsigned(o_sph.data.center_z) == tcs_pkg::SAT_MIN ||
         o_sph.data.sphere_radius == tcs_pkg::SAT_UMAX))
        else $error("overflow flagged without a saturated output");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sph.valid && o_sph.data.degenerate) |->
        (!o_sph.data.overflowed && o_sph.data.sphere_radius == '0 &&
         o_sph.data.center_x == '0 && o_sph.data.center_y == '0 &&
         o_sph.data.center_z == '0))
        else $error("degenerate result not cleared");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_itv[tcs_pkg::QUO_W] && !r_it[tcs_pkg::QUO_W].deg && !r_it[tcs_pkg::QUO_W].dovf[0])
        |-> (r_it[tcs_pkg::QUO_W].drem[0] < tcs_pkg::DREM_W'(r_it[tcs_pkg::QUO_W].den)))
        else $error("center division remainder not below divisor");

    a_root_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_itv[tcs_pkg::QUO_W] && !r_it[tcs_pkg::QUO_W].deg && !r_it[tcs_pkg::QUO_W].sovf)
        |-> (r_it[tcs_pkg::QUO_W].srem < ((tcs_pkg::SREM_W'(r_it[tcs_pkg::QUO_W].yval) << 1)
                                          + tcs_pkg::SREM_W'(r_it[tcs_pkg::QUO_W].tval))))
        else $error("radius root not maximal");

endmodule

`default_nettype wire
